FILE: design/lkvc_pkg.sv
package lkvc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 16;
  localparam int unsigned KEY_BITS        = 16;
  localparam int unsigned VALUE_BITS      = 32;
  localparam int unsigned CAP_BITS        = 5;
  localparam int unsigned CAP_RESET       = 16;
  localparam int unsigned APB_DATA_BITS   = 32;
  localparam int unsigned APB_ADDR_BITS   = 3;

  // Register index, taken from the word address bit of the config port.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [0:0] {
    KIND_LOOKUP = 1'b0,
    KIND_STORE  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    kind_e                  kind;
    logic [KEY_BITS-1:0]    lookup_key;
    logic [VALUE_BITS-1:0]  store_value;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [VALUE_BITS-1:0]  read_value;
    logic                   evicted;
    logic [KEY_BITS-1:0]    evicted_key;
  } out_item_t;

endpackage

FILE: design/lkvc_ram.sv
module lkvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lru_key_value_cache_core.sv
// Each item is handled alone: a scan pass reads one entry per cycle, a decision state,
// a recency pass that rewrites ranks one entry per cycle, and a finish state that loads
// the output register once it is free. A lookup that misses skips the recency pass.
// A new item is accepted only in idle, after the previous result has been loaded.
// Reset clears valid bits, fill count and sets capacity to 16; memories are not cleared.
module lru_key_value_cache_core #(
  parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  lkvc_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output lkvc_pkg::out_item_t                  out_data_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lkvc_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [lkvc_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [lkvc_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > lkvc_pkg::CAP_BITS) ? CNT_W : lkvc_pkg::CAP_BITS;
  localparam int unsigned KB    = lkvc_pkg::KEY_BITS;
  localparam int unsigned VB    = lkvc_pkg::VALUE_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  lkvc_pkg::state_e state_q, state_d;

  lkvc_pkg::in_item_t  req_q;
  lkvc_pkg::out_item_t res_q, res_d;
  lkvc_pkg::out_item_t out_q;
  logic                out_valid_q;

  logic [CNT_W-1:0] cnt_q;
  logic             chk_vld_q;
  logic [IDX_W-1:0] chk_idx_q;

  logic             hit_q, free_q, vic_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q, vic_idx_q;
  logic [IDX_W-1:0] hit_rank_q, vic_rank_q;
  logic [VB-1:0]    hit_val_q;
  logic [KB-1:0]    vic_key_q;

  logic [IDX_W-1:0] tgt_idx_q, tgt_idx_d;
  logic [IDX_W-1:0] old_rank_q, old_rank_d;
  logic             age_all_q, age_all_d;

  logic [ENTRIES-1:0]            valid_q;
  logic [CNT_W-1:0]              fill_q;
  logic [lkvc_pkg::CAP_BITS-1:0] cap_q;

  // Control from the state machine.
  logic in_accept, issue, scan_eval, sweep_eval, decide, fin_load;

  // Memory ports.
  logic [IDX_W-1:0] rd_addr;
  logic [KB-1:0]    key_rd;
  logic [VB-1:0]    val_rd;
  logic [IDX_W-1:0] rank_rd;
  logic             key_we, val_we, rank_we;
  logic [IDX_W-1:0] rank_wdata;

  // Decision signals.
  logic             is_store, room, do_sweep, set_valid;
  logic [CMP_W-1:0] fill_ext, cap_ext, eff_cap;
  logic             entry_valid, key_match;

  assign rd_addr = cnt_q[IDX_W-1:0];

  lkvc_ram #(.WIDTH(KB), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (tgt_idx_d),
    .wdata_i (req_q.lookup_key),
    .raddr_i (rd_addr),
    .rdata_o (key_rd)
  );

  lkvc_ram #(.WIDTH(VB), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (tgt_idx_d),
    .wdata_i (req_q.store_value),
    .raddr_i (rd_addr),
    .rdata_o (val_rd)
  );

  lkvc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (chk_idx_q),
    .wdata_i (rank_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rank_rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lkvc_pkg::ST_SCAN;
      end
      lkvc_pkg::ST_SCAN: begin
        if (chk_vld_q && chk_idx_q == LAST_IDX) state_d = lkvc_pkg::ST_DECIDE;
      end
      lkvc_pkg::ST_DECIDE: begin
        state_d = do_sweep ? lkvc_pkg::ST_SWEEP : lkvc_pkg::ST_FINISH;
      end
      lkvc_pkg::ST_SWEEP: begin
        if (chk_vld_q && chk_idx_q == LAST_IDX) state_d = lkvc_pkg::ST_FINISH;
      end
      lkvc_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = lkvc_pkg::ST_IDLE;
      end
      default: state_d = lkvc_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    scan_eval  = 1'b0;
    sweep_eval = 1'b0;
    decide     = 1'b0;
    fin_load   = 1'b0;
    case (state_q)
      lkvc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      lkvc_pkg::ST_SCAN: begin
        issue     = (cnt_q < CNT_W'(ENTRIES));
        scan_eval = chk_vld_q;
      end
      lkvc_pkg::ST_DECIDE: begin
        decide = 1'b1;
      end
      lkvc_pkg::ST_SWEEP: begin
        issue      = (cnt_q < CNT_W'(ENTRIES));
        sweep_eval = chk_vld_q;
      end
      lkvc_pkg::ST_FINISH: begin
        fin_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  assign in_accept = in_valid_i && in_ready_o;

  // Capacity clamp: zero acts as one, anything above the entry count as the entry count.
  always_comb begin
    fill_ext = CMP_W'(fill_q);
    cap_ext  = CMP_W'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    room = fill_ext < eff_cap;
  end

  assign entry_valid = valid_q[chk_idx_q];
  assign key_match   = entry_valid && (key_rd == req_q.lookup_key);
  assign is_store    = (req_q.kind == lkvc_pkg::KIND_STORE);

  // Decision: pick the entry to touch and build the result beat.
  always_comb begin
    tgt_idx_d  = tgt_idx_q;
    old_rank_d = old_rank_q;
    age_all_d  = 1'b0;
    do_sweep   = 1'b0;
    set_valid  = 1'b0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    res_d      = '0;
    if (hit_q) begin
      tgt_idx_d      = hit_idx_q;
      old_rank_d     = hit_rank_q;
      do_sweep       = 1'b1;
      val_we         = decide && is_store;
      res_d.found    = 1'b1;
      res_d.read_value = is_store ? '0 : hit_val_q;
    end else if (is_store) begin
      do_sweep = 1'b1;
      key_we   = decide;
      val_we   = decide;
      if (room) begin
        tgt_idx_d = free_idx_q;
        age_all_d = 1'b1;
        set_valid = decide;
      end else begin
        tgt_idx_d         = vic_idx_q;
        old_rank_d        = vic_rank_q;
        res_d.evicted     = 1'b1;
        res_d.evicted_key = vic_key_q;
      end
    end
  end

  // Recency: touched entry gets rank zero; newer entries (all, on a fill) age by one.
  always_comb begin
    rank_we    = 1'b0;
    rank_wdata = rank_rd + IDX_W'(1);
    if (sweep_eval) begin
      if (chk_idx_q == tgt_idx_q) begin
        rank_we    = 1'b1;
        rank_wdata = '0;
      end else if (entry_valid && (age_all_q || rank_rd < old_rank_q)) begin
        rank_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lkvc_pkg::ST_IDLE;
      cnt_q       <= '0;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      vic_q       <= 1'b0;
      age_all_q   <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      fill_q      <= '0;
      cap_q       <= lkvc_pkg::CAP_BITS'(lkvc_pkg::CAP_RESET);
    end else begin
      state_q   <= state_d;
      chk_vld_q <= issue;
      if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (in_accept) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        vic_q  <= 1'b0;
      end
      if (scan_eval) begin
        if (key_match && !hit_q) hit_q <= 1'b1;
        if (!entry_valid) free_q <= 1'b1;
        if (entry_valid) vic_q <= 1'b1;
      end
      if (decide) begin
        cnt_q     <= '0;
        age_all_q <= age_all_d;
        if (set_valid) begin
          valid_q[tgt_idx_d] <= 1'b1;
          fill_q             <= fill_q + CNT_W'(1);
        end
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (psel && penable && pwrite && paddr[2] == lkvc_pkg::REG_CAPACITY) begin
        cap_q <= pwdata[lkvc_pkg::CAP_BITS-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_data_i;
    end
    if (issue) begin
      chk_idx_q <= rd_addr;
    end
    if (scan_eval) begin
      if (key_match && !hit_q) begin
        hit_idx_q  <= chk_idx_q;
        hit_rank_q <= rank_rd;
        hit_val_q  <= val_rd;
      end
      if (!entry_valid && !free_q) begin
        free_idx_q <= chk_idx_q;
      end
      if (entry_valid && (!vic_q || rank_rd > vic_rank_q)) begin
        vic_idx_q  <= chk_idx_q;
        vic_rank_q <= rank_rd;
        vic_key_q  <= key_rd;
      end
    end
    if (decide) begin
      tgt_idx_q  <= tgt_idx_d;
      old_rank_q <= old_rank_d;
      res_q      <= res_d;
    end
    if (fin_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lkvc_pkg::REG_CAPACITY) ?
                  lkvc_pkg::APB_DATA_BITS'(cap_q) : '0;

endmodule

FILE: test/lkvc_checker.sv
`timescale 1ns / 100ps
module lkvc_checker
  import lkvc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  in_item_t                 in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  out_item_t                out_data_i,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic                     pready_i,
  input  logic [APB_ADDR_BITS-1:0] paddr_i,
  input  logic [APB_DATA_BITS-1:0] pwdata_i,
  output int                       error_count_o,
  output int                       outstanding_o
);

  localparam int SLOTS = ENTRIES_DEFAULT;

  logic [KEY_BITS-1:0]   slot_key   [SLOTS];
  logic [VALUE_BITS-1:0] slot_value [SLOTS];
  bit                    slot_live  [SLOTS];
  int                    slot_age   [SLOTS];
  int                    live_count;
  logic [CAP_BITS-1:0]   capacity;
  out_item_t             pending_results [$];

  initial error_count_o = 0;

  task automatic report_failure(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count_o = error_count_o + 1;
  endtask

  // Every live slot that was more recent than the promoted one ages by one.
  function automatic void promote(input int idx, input int old_age);
    for (int i = 0; i < SLOTS; i++) begin
      if (i != idx && slot_live[i] && slot_age[i] < old_age) begin
        slot_age[i] = slot_age[i] + 1;
      end
    end
    slot_age[idx] = 0;
  endfunction

  function automatic out_item_t cache_access(input in_item_t item);
    out_item_t res;
    int        hit;
    int        slot;
    int        limit;
    res  = '0;
    hit  = -1;
    slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_live[i] && slot_key[i] == item.lookup_key) begin
        hit = i;
      end
    end
    if (hit >= 0) begin
      res.found = 1'b1;
      if (item.kind == KIND_LOOKUP) begin
        res.read_value = slot_value[hit];
      end else begin
        slot_value[hit] = item.store_value;
      end
      promote(hit, slot_age[hit]);
    end else if (item.kind == KIND_STORE) begin
      limit = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : int'(capacity));
      if (live_count < limit) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !slot_live[i]) begin
            slot = i;
          end
        end
        slot_key[slot]   = item.lookup_key;
        slot_value[slot] = item.store_value;
        promote(slot, SLOTS);
        slot_live[slot]  = 1'b1;
        live_count       = live_count + 1;
      end else begin
        // The victim is the live slot with the highest age.
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && (slot < 0 || slot_age[i] > slot_age[slot])) begin
            slot = i;
          end
        end
        res.evicted      = 1'b1;
        res.evicted_key  = slot_key[slot];
        slot_key[slot]   = item.lookup_key;
        slot_value[slot] = item.store_value;
        promote(slot, slot_age[slot]);
      end
    end
    return res;
  endfunction

  task automatic compare_result(input out_item_t got, input out_item_t want);
    if (got.found !== want.found) begin
      report_failure($sformatf("found: got %b, expected %b", got.found, want.found));
    end
    if (got.read_value !== want.read_value) begin
      report_failure($sformatf("read_value: got %h, expected %h",
                               got.read_value, want.read_value));
    end
    if (got.evicted !== want.evicted) begin
      report_failure($sformatf("evicted: got %b, expected %b", got.evicted, want.evicted));
    end
    if (got.evicted_key !== want.evicted_key) begin
      report_failure($sformatf("evicted_key: got %h, expected %h",
                               got.evicted_key, want.evicted_key));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_age[i]  = 0;
      end
      live_count = 0;
      capacity   = CAP_BITS'(CAP_RESET);
      pending_results.delete();
      outstanding_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i
          && paddr_i == {REG_CAPACITY, 2'b00}) begin
        capacity = pwdata_i[CAP_BITS-1:0];
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.push_back(cache_access(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_failure($sformatf("result beat with nothing pending: %h", out_data_i));
        end else begin
          compare_result(out_data_i, pending_results.pop_front());
        end
      end
      outstanding_o <= pending_results.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
module tb;
  import lkvc_pkg::*;

  localparam int ITEMS_PER_PHASE = 75;
  localparam int PHASES          = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 45;

  logic                     clk_i;
  logic                     rst_ni    = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_data;
  logic                     psel      = 1'b0;
  logic                     penable   = 1'b0;
  logic                     pwrite    = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr     = '0;
  logic [APB_DATA_BITS-1:0] pwdata    = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  bit                       quiet        = 1'b0;
  bit                       hold_request = 1'b0;
  int                       error_count;
  int                       outstanding;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  lru_key_value_cache_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  lkvc_checker watch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : receiver
    int gap;
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 7);
        repeat (gap) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Called just after a rising edge; returns in the step of the accepting edge.
  task automatic send_item(input kind_e kind, input logic [KEY_BITS-1:0] key,
                           input logic [VALUE_BITS-1:0] value);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk_i);
    end
    in_valid            <= 1'b1;
    in_data.kind        <= kind;
    in_data.lookup_key  <= key;
    in_data.store_value <= value;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Lets every result drain, then idles for a settling period.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input int unsigned cap);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= APB_DATA_BITS'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int              caps [PHASES];
    int              pool;
    logic [KEY_BITS-1:0] base;
    logic [KEY_BITS-1:0] key;
    kind_e           kind;
    caps = '{31, 4, 16, 2, 0, 17, 9, 16};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty cache, key and value extremes, hits and misses of both kinds.
    send_item(KIND_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
    send_item(KIND_STORE,  16'h0000, 32'h0000_0000);
    send_item(KIND_STORE,  16'hFFFF, 32'hFFFF_FFFF);
    send_item(KIND_LOOKUP, 16'hFFFF, 32'h0000_0000);
    send_item(KIND_LOOKUP, 16'h0000, 32'hDEAD_BEEF);
    send_item(KIND_STORE,  16'h0000, 32'h1234_5678);
    send_item(KIND_LOOKUP, 16'h0000, 32'h0000_0000);
    send_item(KIND_LOOKUP, 16'h1234, 32'h0000_0000);

    // Capacity dropped below the fill level: misses evict, nothing flushes.
    settle();
    write_capacity(1);
    send_item(KIND_STORE,  16'h00A5, 32'hA5A5_A5A5);
    send_item(KIND_STORE,  16'h5A00, 32'h5A5A_5A5A);
    send_item(KIND_LOOKUP, 16'h5A00, 32'h0000_0000);

    // A capacity of zero behaves as one.
    settle();
    write_capacity(0);
    send_item(KIND_STORE,  16'h1111, 32'h0000_0001);
    send_item(KIND_STORE,  16'h2222, 32'h8000_0000);
    send_item(KIND_LOOKUP, 16'h2222, 32'h0000_0000);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_capacity(caps[p]);
      quiet = (p == PHASES - 1);
      if (p == 1) begin
        hold_request = 1'b1;
      end
      // Keys come mostly from a pool a little larger than the effective capacity, so
      // that hits, refills and evictions all stay frequent.
      pool = (caps[p] == 0) ? 4 : ((caps[p] > 16) ? 19 : caps[p] + 3);
      base = KEY_BITS'($urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          key = KEY_BITS'($urandom);
        end else begin
          key = base + KEY_BITS'($urandom_range(0, pool - 1));
        end
        kind = ($urandom_range(0, 1) != 0) ? KIND_STORE : KIND_LOOKUP;
        send_item(kind, key, VALUE_BITS'($urandom));
      end
    end

    settle();
    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
